/* src/tdcd_pkg.sv */
// shared types and constants of the timed drive command decoder
`timescale 1ns / 1ps
`default_nettype none
package tdcd_pkg;

  localparam int unsigned TickCountBitsDefault = 16;
  localparam int unsigned DurationBits        = 10;
  localparam int unsigned DriveBits           = 3;

  localparam logic [31:0] AccessCodeReset = 32'h3330_3631;

  // drive codes seen on the result channel
  typedef enum logic [DriveBits-1:0] {
    DRV_OFF = 3'd0,
    DRV_FWD = 3'd1,
    DRV_REV = 3'd2,
    DRV_CW  = 3'd3,
    DRV_CCW = 3'd4
  } drive_e;

  // what the parser hands to the motion timer for one byte
  typedef struct packed {
    logic                    take;
    logic                    stop;
    logic                    start;
    drive_e                  drive;
    logic [DurationBits-1:0] duration;
  } cmd_t;

  // one result item
  typedef struct packed {
    drive_e drive;
    logic   command_taken;
    logic   motion_done;
  } result_t;

endpackage
`default_nettype wire

/* src/tdcd_in_if.sv */
// input channel: received bytes and timer ticks
`timescale 1ns / 1ps
`default_nettype none
interface tdcd_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface
`default_nettype wire

/* src/tdcd_out_if.sv */
// result channel: drive state and event flags
`timescale 1ns / 1ps
`default_nettype none
interface tdcd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] drive;
  logic       command_taken;
  logic       motion_done;

  modport source (output valid, output drive, output command_taken, output motion_done,
                  input ready);
  modport sink   (input valid, input drive, input command_taken, input motion_done,
                  output ready);
endinterface
`default_nettype wire

/* src/tdcd_frame_parser.sv */
// byte-level command frame parser
`timescale 1ns / 1ps
`default_nettype none
module tdcd_frame_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         byte_valid_i,
  input  wire logic [7:0]   byte_i,
  input  wire logic [31:0]  access_code_i,
  output tdcd_pkg::cmd_t    cmd_o
);
  import tdcd_pkg::*;

  localparam logic [3:0] PosHunt   = 4'd0;
  localparam logic [3:0] PosCode0  = 4'd1;
  localparam logic [3:0] PosCode1  = 4'd2;
  localparam logic [3:0] PosCode2  = 4'd3;
  localparam logic [3:0] PosCode3  = 4'd4;
  localparam logic [3:0] PosLetter = 4'd5;
  localparam logic [3:0] PosDigit0 = 4'd6;
  localparam logic [3:0] PosDigit1 = 4'd7;
  localparam logic [3:0] PosDigit2 = 4'd8;

  localparam logic [7:0] StartMark = 8'h5E;
  localparam logic [7:0] ChrZero   = 8'h30;
  localparam logic [7:0] ChrNine   = 8'h39;
  localparam logic [7:0] ChrF      = 8'h46;
  localparam logic [7:0] ChrB      = 8'h42;
  localparam logic [7:0] ChrR      = 8'h52;
  localparam logic [7:0] ChrL      = 8'h4C;
  localparam logic [7:0] ChrS      = 8'h53;

  localparam int unsigned AccW = DurationBits + 4;

  logic [3:0]              pos_q, pos_d;
  drive_e                  pend_q, pend_d;
  logic [DurationBits-1:0] acc_q, acc_d;

  logic [7:0]              want;
  drive_e                  letter;
  logic [AccW-1:0]         acc_wide;
  logic [DurationBits-1:0] acc_next;

  always_comb begin
    unique case (pos_q)
      PosCode0: want = access_code_i[31:24];
      PosCode1: want = access_code_i[23:16];
      PosCode2: want = access_code_i[15:8];
      default:  want = access_code_i[7:0];
    endcase
  end

  always_comb begin
    unique case (byte_i)
      ChrF:    letter = DRV_FWD;
      ChrB:    letter = DRV_REV;
      ChrR:    letter = DRV_CW;
      ChrL:    letter = DRV_CCW;
      default: letter = DRV_OFF;
    endcase
  end

  // decimal shift-in, wrapped to the duration width
  assign acc_wide = {{(AccW-DurationBits){1'b0}}, acc_q} * AccW'(10)
                  + {{(AccW-4){1'b0}}, byte_i[3:0]};
  assign acc_next = acc_wide[DurationBits-1:0];

  always_comb begin
    pos_d  = pos_q;
    pend_d = pend_q;
    acc_d  = acc_q;
    cmd_o  = '0;
    if (byte_valid_i) begin
      priority if (pos_q >= PosCode0 && pos_q <= PosCode3) begin
        if (byte_i == want) begin
          pos_d = pos_q + 4'd1;
        end else begin
          pos_d = (byte_i == StartMark) ? PosCode0 : PosHunt;
        end
      end else if (byte_i == StartMark) begin
        pos_d = PosCode0;
      end else if (pos_q == PosLetter) begin
        if (byte_i == ChrS) begin
          cmd_o.take = 1'b1;
          cmd_o.stop = 1'b1;
          pos_d      = PosHunt;
        end else begin
          pend_d = letter;
          acc_d  = '0;
          pos_d  = (letter != DRV_OFF) ? PosDigit0 : PosHunt;
        end
      end else if (pos_q >= PosDigit0 && pos_q <= PosDigit2) begin
        if (byte_i < ChrZero || byte_i > ChrNine) begin
          pos_d = PosHunt;
        end else begin
          acc_d = acc_next;
          if (pos_q != PosDigit2) begin
            pos_d = pos_q + 4'd1;
          end else begin
            cmd_o.take     = 1'b1;
            cmd_o.start    = 1'b1;
            cmd_o.drive    = pend_q;
            cmd_o.duration = acc_next;
            pos_d          = PosHunt;
          end
        end
      end else begin
        pos_d = PosHunt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= PosHunt;
      pend_q <= DRV_OFF;
      acc_q  <= '0;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
      acc_q  <= acc_d;
    end
  end

endmodule
`default_nettype wire

/* src/tdcd_motion_timer.sv */
// drive state, elapsed tick counter and expiry check
`timescale 1ns / 1ps
`default_nettype none
module tdcd_motion_timer #(
  parameter int unsigned TickCountBits = tdcd_pkg::TickCountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        tick_i,
  input  tdcd_pkg::cmd_t   cmd_i,
  output tdcd_pkg::result_t result_o
);
  import tdcd_pkg::*;

  drive_e                   drive_q, drive_d, drive_mid;
  logic [DurationBits-1:0]  target_q, target_d;
  logic [TickCountBits-1:0] elapsed_q, elapsed_d, elapsed_mid;
  logic [TickCountBits-1:0] target_ext;
  logic                     ended;

  always_comb begin
    elapsed_mid = elapsed_q;
    if (tick_i && elapsed_q != '1) begin
      elapsed_mid = elapsed_q + TickCountBits'(1);
    end
    if (cmd_i.take) begin
      elapsed_mid = '0;
    end

    drive_mid = drive_q;
    target_d  = target_q;
    if (cmd_i.stop) begin
      drive_mid = DRV_OFF;
    end else if (cmd_i.start) begin
      drive_mid = cmd_i.drive;
      target_d  = cmd_i.duration;
    end
  end

  assign target_ext = TickCountBits'(target_d);

  // straight runs end past the duration, spins end on reaching it
  always_comb begin
    unique case (drive_mid)
      DRV_FWD, DRV_REV: ended = elapsed_mid > target_ext;
      DRV_CW, DRV_CCW:  ended = elapsed_mid >= target_ext;
      default:          ended = 1'b0;
    endcase
  end

  always_comb begin
    drive_d   = ended ? DRV_OFF : drive_mid;
    elapsed_d = ended ? '0 : elapsed_mid;
    if (drive_mid > DRV_CCW) begin
      drive_d = DRV_OFF;
    end
    result_o.drive         = drive_d;
    result_o.command_taken = cmd_i.take;
    result_o.motion_done   = ended;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q   <= DRV_OFF;
      target_q  <= '0;
      elapsed_q <= '0;
    end else if (step_i) begin
      drive_q   <= drive_d;
      target_q  <= target_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule
`default_nettype wire

/* src/timed_drive_command_decoder_top.sv */
// top level of the timed drive command decoder
//
//  channel  dir  handshake    payload
//  in_i     in   valid/ready  mode, rx_byte
//  out_o    out  valid/ready  drive, command_taken, motion_done
//  cfg      in   cfg_we_i     cfg_wdata_i (access code, first char in top byte)
//
// one item per cycle sustained while the result is not stalled; an item passes
// through the input register and then the result register
// the state update runs in the cycle the input register moves into the result register
// reset clears the parser, drive, elapsed count and both valid flags; access code
// returns to "3061"
// a stalled result holds the pipe; the input register still fills behind it
`timescale 1ns / 1ps
`default_nettype none
module timed_drive_command_decoder_top #(
  parameter int unsigned TickCountBits = tdcd_pkg::TickCountBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tdcd_in_if.sink          in_i,
  tdcd_out_if.source       out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);
  import tdcd_pkg::*;

  // access code register
  logic [31:0] access_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      access_code_q <= AccessCodeReset;
    end else if (cfg_we_i) begin
      access_code_q <= cfg_wdata_i;
    end
  end

  // input register stage
  logic       s1_valid_q;
  logic       s1_mode_q;
  logic [7:0] s1_byte_q;
  logic       advance;
  logic       in_transfer;

  // result register stage
  logic    out_valid_q;
  result_t out_q;
  result_t step_result;
  cmd_t    cmd;

  // step the state when the result register is free or being drained
  assign advance     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign in_transfer = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_transfer) begin
      s1_mode_q <= in_i.mode;
      s1_byte_q <= in_i.rx_byte;
    end
  end

  // frame parsing, only on byte items
  tdcd_frame_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (advance && !s1_mode_q),
    .byte_i        (s1_byte_q),
    .access_code_i (access_code_q),
    .cmd_o         (cmd)
  );

  // drive and elapsed tracking
  tdcd_motion_timer #(
    .TickCountBits (TickCountBits)
  ) u_timer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .tick_i   (advance && s1_mode_q),
    .cmd_i    (cmd),
    .result_o (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= step_result;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drive         = out_q.drive;
  assign out_o.command_taken = out_q.command_taken;
  assign out_o.motion_done   = out_q.motion_done;

  // an empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // every input transfer lands in the input register
  a_transfer_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_transfer |=> s1_valid_q)
    else $error("input transfer lost");

  // an expiry always leaves the wheels off
  a_done_means_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.motion_done) |-> (out_q.drive == DRV_OFF))
    else $error("motion done with drive still on");

  // drive code stays within the defined set
  a_drive_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.drive <= DRV_CCW))
    else $error("illegal drive code");

endmodule
`default_nettype wire
